[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the Ising sweep unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

[hdl/isms_pkg.sv]
// Package with the constants and types of the Ising sweep unit.
package isms_pkg;

  // Default lattice side length.
  localparam int unsigned LatticeSideDef = 16;

  // Widths of the data fields.
  localparam int unsigned ProbW   = 16;
  localparam int unsigned RowW    = 4;
  localparam int unsigned ColW    = 4;
  localparam int unsigned EnergyW = 11;
  localparam int unsigned MagnetW = 10;
  localparam int unsigned AcceptW = 9;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegProbFour  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegProbEight = 1'b1;

  // Configuration reset values.
  localparam logic [ProbW-1:0] ProbFourRst  = 16'd1200;
  localparam logic [ProbW-1:0] ProbEightRst = 16'd22;

  // Neighbor spins of the site under update.
  typedef struct packed {
    logic north;
    logic south;
    logic west;
    logic east;
  } nbr_t;

  // Metropolis decision handed from the update logic to the top level.
  typedef struct packed {
    logic               flip;
    logic [EnergyW-1:0] energy_delta;
    logic [MagnetW-1:0] magnet_delta;
  } decision_t;

endpackage

[hdl/isms_cell.sv]
// One spin cell of the rotating lattice ring.
module isms_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic spin_i,
  output logic spin_o
);

  logic spin_q;
  logic spin_d;

  // Take the neighbor's spin when the ring advances.
  assign spin_d = shift_i ? spin_i : spin_q;

  // Every spin starts at +1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_q <= 1'b1;
    end else begin
      spin_q <= spin_d;
    end
  end

  assign spin_o = spin_q;

endmodule

[hdl/isms_update.sv]
// Metropolis acceptance logic for the site under update.
module isms_update (
  input  logic                          center_i,
  input  isms_pkg::nbr_t                nbr_i,
  input  logic [isms_pkg::ProbW-1:0]    random_value_i,
  input  logic [isms_pkg::ProbW-1:0]    prob_four_i,
  input  logic [isms_pkg::ProbW-1:0]    prob_eight_i,
  output isms_pkg::decision_t           decision_o
);

  logic [3:0] same;
  logic [2:0] n_same;
  logic       flip;

  // Count neighbors that share the center spin; dE = 4 * n_same - 8.
  assign same   = ~({nbr_i.north, nbr_i.south, nbr_i.west, nbr_i.east} ^ {4{center_i}});
  assign n_same = {2'b00, same[0]} + {2'b00, same[1]} + {2'b00, same[2]} + {2'b00, same[3]};

  // Accept when dE is not positive, else compare against the threshold.
  always_comb begin
    case (n_same)
      3'd0, 3'd1, 3'd2: flip = 1'b1;
      3'd3:             flip = random_value_i < prob_four_i;
      3'd4:             flip = random_value_i < prob_eight_i;
      default:          flip = 1'b0;
    endcase
  end

  // Energy step and magnetization step of a flip.
  assign decision_o.flip         = flip;
  assign decision_o.energy_delta = {(isms_pkg::EnergyW - 5)'(0), n_same, 2'b00}
                                   - isms_pkg::EnergyW'(8);
  assign decision_o.magnet_delta = center_i ? -isms_pkg::MagnetW'(2)
                                            : isms_pkg::MagnetW'(2);

endmodule

[hdl/ising_metropolis_sweep_unit.sv]
// Top level of the Ising lattice Metropolis sweep unit.
// The lattice is a ring of one-spin cells that rotates by one cell for every
// accepted item, so the site under update always sits in cell 0 and its four
// neighbors sit at fixed taps of the ring. An item is accepted in every cycle
// in which the output register is empty or being emptied, and its result
// appears in the output register in the next cycle: one item per cycle, as
// the ring rotates and updates as each item is accepted. After reset all
// spins are +1 and the unit is ready at once; no clearing pass is needed.
`include "assert_macros.svh"

module ising_metropolis_sweep_unit #(
  parameter int unsigned LATTICE_SIDE = isms_pkg::LatticeSideDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [isms_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [isms_pkg::ProbW-1:0]          cfg_data_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [isms_pkg::ProbW-1:0]          random_value_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [isms_pkg::RowW-1:0]           site_row_o,
  output logic [isms_pkg::ColW-1:0]           site_col_o,
  output logic                                flipped_o,
  output logic signed [isms_pkg::EnergyW-1:0] total_energy_o,
  output logic signed [isms_pkg::MagnetW-1:0] total_magnet_o,
  output logic [isms_pkg::AcceptW-1:0]        sweep_accepts_o,
  output logic                                sweep_end_o
);

  localparam int unsigned SiteCount = LATTICE_SIDE * LATTICE_SIDE;
  localparam int unsigned PosW      = $clog2(LATTICE_SIDE);
  localparam logic [PosW-1:0] PosLast = PosW'(LATTICE_SIDE - 1);

  // Fixed taps of the ring relative to the current site.
  localparam int unsigned TapEast     = 1;
  localparam int unsigned TapEastWrap = SiteCount - LATTICE_SIDE + 1;
  localparam int unsigned TapWest     = SiteCount - 1;
  localparam int unsigned TapWestWrap = LATTICE_SIDE - 1;
  localparam int unsigned TapSouth    = LATTICE_SIDE;
  localparam int unsigned TapNorth    = SiteCount - LATTICE_SIDE;

  logic [SiteCount-1:0] ring;
  logic                 new_spin;
  logic                 in_fire;

  logic [isms_pkg::ProbW-1:0]   prob_four_q, prob_eight_q;
  logic [PosW-1:0]              row_q, row_d, col_q, col_d;
  logic [isms_pkg::EnergyW-1:0] energy_q, energy_d;
  logic [isms_pkg::MagnetW-1:0] magnet_q, magnet_d;
  logic [isms_pkg::AcceptW-1:0] accepts_q, accepts_d, accepts_base;
  logic                         col_last, row_last, sweep_first, sweep_last;
  logic                         out_valid_q;

  isms_pkg::nbr_t      nbr;
  isms_pkg::decision_t decision;

  // Handshake: take an item whenever the output register can be refilled.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_four_q  <= isms_pkg::ProbFourRst;
      prob_eight_q <= isms_pkg::ProbEightRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        isms_pkg::RegProbFour:  prob_four_q  <= cfg_data_i;
        isms_pkg::RegProbEight: prob_eight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ring of spin cells; the updated center spin re-enters at the far end.
  assign new_spin = ring[0] ^ decision.flip;

  for (genvar k = 0; k < SiteCount; k++) begin : g_cell
    logic spin_in;
    if (k == SiteCount - 1) begin : g_tail
      assign spin_in = new_spin;
    end else begin : g_body
      assign spin_in = ring[k+1];
    end
    isms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_fire),
      .spin_i  (spin_in),
      .spin_o  (ring[k])
    );
  end

  // Site position within the sweep.
  assign col_last    = col_q == PosLast;
  assign row_last    = row_q == PosLast;
  assign sweep_first = (row_q == '0) && (col_q == '0);
  assign sweep_last  = row_last && col_last;

  // Neighbor taps, with periodic wrap at the row ends.
  assign nbr.north = ring[TapNorth];
  assign nbr.south = ring[TapSouth];
  assign nbr.west  = (col_q == '0) ? ring[TapWestWrap] : ring[TapWest];
  assign nbr.east  = col_last ? ring[TapEastWrap] : ring[TapEast];

  isms_update u_update (
    .center_i       (ring[0]),
    .nbr_i          (nbr),
    .random_value_i (random_value_i),
    .prob_four_i    (prob_four_q),
    .prob_eight_i   (prob_eight_q),
    .decision_o     (decision)
  );

  // Next values of the position and the running sums.
  always_comb begin
    col_d        = col_last ? '0 : col_q + PosW'(1);
    row_d        = col_last ? (row_last ? '0 : row_q + PosW'(1)) : row_q;
    accepts_base = sweep_first ? '0 : accepts_q;
    accepts_d    = accepts_base + isms_pkg::AcceptW'(decision.flip);
    energy_d     = decision.flip ? energy_q + decision.energy_delta : energy_q;
    magnet_d     = decision.flip ? magnet_q + decision.magnet_delta : magnet_q;
  end

  // Sweep state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      accepts_q <= '0;
      energy_q  <= isms_pkg::EnergyW'(-2 * longint'(SiteCount));
      magnet_q  <= isms_pkg::MagnetW'(SiteCount);
    end else if (in_fire) begin
      row_q     <= row_d;
      col_q     <= col_d;
      accepts_q <= accepts_d;
      energy_q  <= energy_d;
      magnet_q  <= magnet_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      site_row_o      <= isms_pkg::RowW'(32'(row_q));
      site_col_o      <= isms_pkg::ColW'(32'(col_q));
      flipped_o       <= decision.flip;
      total_energy_o  <= energy_d;
      total_magnet_o  <= magnet_d;
      sweep_accepts_o <= accepts_d;
      sweep_end_o     <= sweep_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // A flip always changes the magnetization, which moves by two.
  `ASSERT_NEXT(a_flip_moves_magnet, clk_i, rst_ni, in_fire && decision.flip,
               magnet_q != $past(magnet_q), "flip left magnetization unchanged")

  // A rejected step leaves the energy alone.
  `ASSERT_NEXT(a_reject_keeps_energy, clk_i, rst_ni, in_fire && !decision.flip,
               energy_q == $past(energy_q), "rejected step changed energy")

  // The result register reports the flag computed for the accepted item.
  `ASSERT_NEXT(a_result_flag, clk_i, rst_ni, in_fire,
               out_valid_o && (flipped_o == $past(decision.flip)), "result flag mismatch")

  // The column never leaves the lattice.
  `ASSERT_IMPLY(a_col_range, clk_i, rst_ni, 1'b1, col_q <= PosLast, "column out of range")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for the Ising lattice Metropolis sweep unit, checked against a lattice predictor.
module tb_top;

  localparam int unsigned Side       = isms_pkg::LatticeSideDef;
  localparam int unsigned Sites      = Side * Side;
  localparam int unsigned QuietLimit = 2500;

  // One expected result item, in the block's own field widths.
  typedef struct packed {
    logic [isms_pkg::RowW-1:0]           row;
    logic [isms_pkg::ColW-1:0]           col;
    logic                                flipped;
    logic signed [isms_pkg::EnergyW-1:0] energy;
    logic signed [isms_pkg::MagnetW-1:0] magnet;
    logic [isms_pkg::AcceptW-1:0]        accepts;
    logic                                sweep_end;
  } site_result_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_we_i       = 1'b0;
  logic [isms_pkg::CfgIdxW-1:0] cfg_index_i    = isms_pkg::RegProbFour;
  logic [isms_pkg::ProbW-1:0]   cfg_data_i     = '0;
  logic                         in_valid_i     = 1'b0;
  logic [isms_pkg::ProbW-1:0]   random_value_i = '0;
  logic                         out_ready_i    = 1'b0;

  logic                                in_ready_o;
  logic                                out_valid_o;
  logic [isms_pkg::RowW-1:0]           site_row_o;
  logic [isms_pkg::ColW-1:0]           site_col_o;
  logic                                flipped_o;
  logic signed [isms_pkg::EnergyW-1:0] total_energy_o;
  logic signed [isms_pkg::MagnetW-1:0] total_magnet_o;
  logic [isms_pkg::AcceptW-1:0]        sweep_accepts_o;
  logic                                sweep_end_o;

  // Lattice predictor state and its copy of the thresholds.
  bit                         spin_up [Sites];
  int                         energy_now;
  int                         magnet_now;
  int unsigned                site_ptr;
  int unsigned                flips_this_sweep;
  logic [isms_pkg::ProbW-1:0] thr_four;
  logic [isms_pkg::ProbW-1:0] thr_eight;

  site_result_t pending_results [$];
  int unsigned  fail_count     = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_off_left  = 0;

  ising_metropolis_sweep_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .site_row_o     (site_row_o),
    .site_col_o     (site_col_o),
    .flipped_o      (flipped_o),
    .total_energy_o (total_energy_o),
    .total_magnet_o (total_magnet_o),
    .sweep_accepts_o(sweep_accepts_o),
    .sweep_end_o    (sweep_end_o)
  );

  // Free-running clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Spin at a site with periodic wrap, as +1 or -1.
  function automatic int spin_of(input int unsigned row, input int unsigned col);
    return spin_up[(row % Side) * Side + (col % Side)] ? 1 : -1;
  endfunction

  // Aligned lattice and reset thresholds.
  function automatic void reset_lattice_model();
    foreach (spin_up[i]) spin_up[i] = 1'b1;
    energy_now       = -2 * int'(Sites);
    magnet_now       = int'(Sites);
    site_ptr         = 0;
    flips_this_sweep = 0;
    thr_four         = isms_pkg::ProbFourRst;
    thr_eight        = isms_pkg::ProbEightRst;
  endfunction

  // Metropolis step at the current site; queues the result it must produce.
  function automatic void predict_site(input logic [isms_pkg::ProbW-1:0] rnd);
    int unsigned  row;
    int unsigned  col;
    int           s;
    int           nsum;
    int           de;
    bit           flip;
    site_result_t res;
    row = site_ptr / Side;
    col = site_ptr % Side;
    s   = spin_of(row, col);
    if (site_ptr == 0) flips_this_sweep = 0;
    nsum = spin_of(row + Side - 1, col) + spin_of(row + 1, col)
         + spin_of(row, col + Side - 1) + spin_of(row, col + 1);
    de = 2 * s * nsum;
    if (de <= 0) flip = 1'b1;
    else if (de == 4) flip = (rnd < thr_four);
    else if (de == 8) flip = (rnd < thr_eight);
    else flip = 1'b0;
    if (flip) begin
      spin_up[site_ptr] = !spin_up[site_ptr];
      energy_now += de;
      magnet_now -= 2 * s;
      flips_this_sweep++;
    end
    res.row       = isms_pkg::RowW'(row);
    res.col       = isms_pkg::ColW'(col);
    res.flipped   = flip;
    res.energy    = isms_pkg::EnergyW'(energy_now);
    res.magnet    = isms_pkg::MagnetW'(magnet_now);
    res.accepts   = isms_pkg::AcceptW'(flips_this_sweep);
    res.sweep_end = (site_ptr == Sites - 1);
    site_ptr = res.sweep_end ? 0 : site_ptr + 1;
    pending_results.push_back(res);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Result checker: every accepted result item against the oldest expectation.
  initial begin : result_checker
    site_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: result item with none expected, expected nothing, got row %0d col %0d",
                   $time, site_row_o, site_col_o);
        end else begin
          want = pending_results.pop_front();
          check_field("site_row", want.row, site_row_o);
          check_field("site_col", want.col, site_col_o);
          check_field("flipped", want.flipped, flipped_o);
          check_field("total_energy", want.energy, total_energy_o);
          check_field("total_magnet", want.magnet, total_magnet_o);
          check_field("sweep_accepts", want.accepts, sweep_accepts_o);
          check_field("sweep_end", want.sweep_end, sweep_end_o);
        end
      end
    end
  end

  // Result sink: random stalls, or a long hold-off when one is requested.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Offers one random value, with optional idle cycles first, and predicts it once accepted.
  task automatic send_item(input logic [isms_pkg::ProbW-1:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    random_value_i <= rnd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_site(rnd);
  endtask

  // Stops offering and waits until every expected result item has arrived.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes both thresholds while the block is idle.
  task automatic set_thresholds(input logic [isms_pkg::ProbW-1:0] four,
                                input logic [isms_pkg::ProbW-1:0] eight);
    wait_all_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= isms_pkg::RegProbFour;
    cfg_data_i  <= four;
    @(posedge clk_i);
    cfg_index_i <= isms_pkg::RegProbEight;
    cfg_data_i  <= eight;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    thr_four  = four;
    thr_eight = eight;
    @(posedge clk_i);
  endtask

  // Mostly uniform values, with extra weight on the threshold edges and the extremes.
  function automatic logic [isms_pkg::ProbW-1:0] pick_random_value();
    int unsigned sel;
    int          v;
    sel = $urandom_range(99);
    if (sel < 60) return isms_pkg::ProbW'($urandom_range(65535));
    if (sel < 90) begin
      v = (sel < 75) ? int'(thr_four) : int'(thr_eight);
      v = v + int'($urandom_range(2)) - 1;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return isms_pkg::ProbW'(v);
    end
    return (sel < 95) ? '0 : '1;
  endfunction

  task automatic send_random_items(input int unsigned count);
    repeat (count) send_item(pick_random_value());
  endtask

  // Aligned start under the reset thresholds: strict compare at 22 and 1200.
  task automatic test_aligned_start();
    send_item(16'd22);
    send_item(16'd21);
    send_item(16'd1200);
    send_item(16'd65535);
    send_item(16'd0);
    send_item(16'd1199);
    send_item(16'd0);
  endtask

  // Zero thresholds never accept; full thresholds accept all but the top value.
  task automatic test_threshold_extremes();
    set_thresholds('0, '0);
    send_item(16'd0);
    send_item(16'd0);
    set_thresholds('1, '1);
    send_item(16'd65535);
    send_item(16'd65534);
    send_item(16'd65534);
    for (int i = 0; i < 9; i++) send_item((i % 2 == 0) ? 16'd0 : 16'd65535);
  endtask

  task automatic test_mid_temperature();
    set_thresholds(16'd40000, 16'd16000);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_items(300);
  endtask

  task automatic test_hot_lattice_sender_gaps();
    set_thresholds('1, '1);
    send_idle_pct  = 45;
    recv_stall_pct = 0;
    send_random_items(150);
  endtask

  task automatic test_frozen_lattice_receiver_stalls();
    set_thresholds('0, '0);
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    send_random_items(150);
  endtask

  task automatic test_random_thresholds_both_idle();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    repeat (3) begin
      set_thresholds(isms_pkg::ProbW'($urandom_range(65535)),
                     isms_pkg::ProbW'($urandom_range(65535)));
      send_random_items(100);
    end
  endtask

  // Long receiver hold-off fills the block; then the sender pauses until all results are in.
  task automatic test_output_backpressure();
    set_thresholds(isms_pkg::ProbW'($urandom_range(65535)),
                   isms_pkg::ProbW'($urandom_range(20000)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 300;
    send_random_items(60);
    wait_all_results();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    send_random_items(100);
  endtask

  initial begin
    reset_lattice_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_aligned_start();
    test_threshold_extremes();
    test_mid_temperature();
    test_hot_lattice_sender_gaps();
    test_frozen_lattice_receiver_stalls();
    test_random_thresholds_both_idle();
    test_output_backpressure();
    wait_all_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[ising_metropolis_sweep_unit.f]
+incdir+hdl
hdl/isms_pkg.sv
hdl/isms_cell.sv
hdl/isms_update.sv
hdl/ising_metropolis_sweep_unit.sv
tb/tb_top.sv
